// ===== src/zrci_pkg.sv =====
// zrci_pkg: shared types, constants and the query program rom for the
// register capture injector. No dependencies.
`default_nettype none

package zrci_pkg;

  localparam int unsigned ProgLen = 36;
  localparam int unsigned NumRegs = 14;

  localparam int unsigned PosW = 6;
  localparam int unsigned RegIdxW = 4;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;

  // program positions that decode writes or hold patched bytes
  localparam pos_t POS_FIRST = 6'd0;
  localparam pos_t POS_AF_PUSH = 6'd1;
  localparam pos_t POS_HL_R = 6'd4;
  localparam pos_t POS_I = 6'd7;
  localparam pos_t POS_DE = 6'd10;
  localparam pos_t POS_BC = 6'd11;
  localparam pos_t POS_HL2 = 6'd13;
  localparam pos_t POS_DE2 = 6'd14;
  localparam pos_t POS_BC2 = 6'd15;
  localparam pos_t POS_AF2_PUSH = 6'd18;
  localparam pos_t POS_IX_PUSH = 6'd23;
  localparam pos_t POS_IY_PUSH = 6'd27;
  localparam pos_t POS_R_PATCH = 6'd28;
  localparam pos_t POS_F_PATCH = 6'd32;
  localparam pos_t POS_A_PATCH = 6'd33;
  localparam pos_t POS_GRAB = 6'd34;
  localparam pos_t POS_END = pos_t'(ProgLen - 1);

  // register indexes
  localparam reg_idx_t RI_PC = 4'd0;
  localparam reg_idx_t RI_SP = 4'd1;
  localparam reg_idx_t RI_AF = 4'd2;
  localparam reg_idx_t RI_BC = 4'd3;
  localparam reg_idx_t RI_DE = 4'd4;
  localparam reg_idx_t RI_HL = 4'd5;
  localparam reg_idx_t RI_AF2 = 4'd6;
  localparam reg_idx_t RI_BC2 = 4'd7;
  localparam reg_idx_t RI_DE2 = 4'd8;
  localparam reg_idx_t RI_HL2 = 4'd9;
  localparam reg_idx_t RI_IX = 4'd10;
  localparam reg_idx_t RI_IY = 4'd11;
  localparam reg_idx_t RI_I = 4'd12;
  localparam reg_idx_t RI_R = 4'd13;
  localparam reg_idx_t RI_LAST = reg_idx_t'(NumRegs - 1);

  typedef enum logic [1:0] {
    PROG_GENERAL = 2'd0,
    PROG_GRAB    = 2'd1,
    PROG_DONE    = 2'd2
  } progress_t;

  typedef struct packed {
    logic [7:0] drive_byte;
    progress_t  progress;
    logic       done;
  } zrci_status_t;

  function automatic logic [7:0] query_byte(input pos_t pos);
    logic [7:0] b;
    case (pos)
      6'd0:  b = 8'hF5;
      6'd1:  b = 8'hED;
      6'd2:  b = 8'h5F;
      6'd3:  b = 8'h77;
      6'd4:  b = 8'hED;
      6'd5:  b = 8'h57;
      6'd6:  b = 8'h77;
      6'd7:  b = 8'h33;
      6'd8:  b = 8'h33;
      6'd9:  b = 8'h12;
      6'd10: b = 8'h02;
      6'd11: b = 8'hD9;
      6'd12: b = 8'h77;
      6'd13: b = 8'h12;
      6'd14: b = 8'h02;
      6'd15: b = 8'hD9;
      6'd16: b = 8'h08;
      6'd17: b = 8'hF5;
      6'd18: b = 8'h33;
      6'd19: b = 8'h33;
      6'd20: b = 8'h08;
      6'd21: b = 8'hDD;
      6'd22: b = 8'hE5;
      6'd23: b = 8'h33;
      6'd24: b = 8'h33;
      6'd25: b = 8'hFD;
      6'd26: b = 8'hE5;
      6'd27: b = 8'h3E;
      6'd28: b = 8'h00;
      6'd29: b = 8'hED;
      6'd30: b = 8'h4F;
      6'd31: b = 8'hF1;
      6'd32: b = 8'h00;
      6'd33: b = 8'h00;
      6'd34: b = 8'h18;
      6'd35: b = 8'hDE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/zrci_in_if.sv =====
// zrci_in_if: bus cycle channel, valid/ready with address, data and direction.
// Depends on nothing.
`default_nettype none

interface zrci_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_addr;
  logic [7:0]  bus_data;
  logic        is_write;

  modport source (output valid, output bus_addr, output bus_data, output is_write,
                  input ready);
  modport sink (input valid, input bus_addr, input bus_data, input is_write,
                output ready);
endinterface

`default_nettype wire

// ===== src/zrci_out_if.sv =====
// zrci_out_if: result channel, valid/ready with drive byte, progress and
// captured register payload. Depends on nothing.
`default_nettype none

interface zrci_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  drive_byte;
  logic        inject_flag;
  logic [1:0]  progress;
  logic        reg_valid;
  logic [3:0]  reg_index;
  logic [15:0] reg_value;
  logic        last;

  modport source (output valid, output drive_byte, output inject_flag, output progress,
                  output reg_valid, output reg_index, output reg_value, output last,
                  input ready);
  modport sink (input valid, input drive_byte, input inject_flag, input progress,
                input reg_valid, input reg_index, input reg_value, input last,
                output ready);
endinterface

`default_nettype wire

// ===== src/zrci_core.sv =====
// zrci_core: program position, push sequencing, patch bytes and the captured
// register file. Uses zrci_pkg.
`default_nettype none

module zrci_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [15:0]       bus_addr,
  input  wire logic [7:0]        bus_data,
  input  wire logic              is_write,
  input  wire zrci_pkg::reg_idx_t rd_idx,
  output zrci_pkg::zrci_status_t status,
  output logic [15:0]            rd_value
);
  import zrci_pkg::*;

  pos_t        position, position_next;
  logic        pending, pending_next;
  logic [7:0]  patch_r, patch_r_next;
  logic [7:0]  patch_a, patch_a_next;
  logic [7:0]  patch_f, patch_f_next;
  logic [15:0] regs [NumRegs];
  logic [15:0] regs_next [NumRegs];
  logic [7:0]  r_val;
  logic [7:0]  prog_byte;
  pos_t        push_idx_pos;
  reg_idx_t    push_idx;
  logic        is_push;

  always_comb begin
    case (position)
      POS_R_PATCH: prog_byte = patch_r;
      POS_F_PATCH: prog_byte = patch_f;
      POS_A_PATCH: prog_byte = patch_a;
      default:     prog_byte = query_byte(position);
    endcase
  end

  assign push_idx_pos = position;
  always_comb begin
    is_push = 1'b1;
    case (push_idx_pos)
      POS_AF2_PUSH: push_idx = RI_AF2;
      POS_IX_PUSH:  push_idx = RI_IX;
      POS_IY_PUSH:  push_idx = RI_IY;
      default: begin
        push_idx = RI_AF2;
        is_push  = 1'b0;
      end
    endcase
  end

  assign r_val = bus_data - 8'd3;

  always_comb begin
    position_next = position;
    pending_next  = pending;
    patch_r_next  = patch_r;
    patch_a_next  = patch_a;
    patch_f_next  = patch_f;
    regs_next     = regs;
    status.drive_byte = 8'h00;
    status.done       = 1'b0;
    status.progress   = PROG_GENERAL;
    if (is_write) begin
      if (is_push) begin
        if (!pending) begin
          regs_next[push_idx][15:8] = bus_data;
          pending_next = 1'b1;
        end else begin
          regs_next[push_idx][7:0] = bus_data;
        end
      end
      case (position)
        POS_AF_PUSH: begin
          if (!pending) begin
            regs_next[RI_SP] = bus_addr + 16'd1;
            regs_next[RI_AF] = {bus_data, 8'h00};
            patch_a_next     = bus_data;
            pending_next     = 1'b1;
          end else begin
            regs_next[RI_AF][7:0] = bus_data;
            patch_f_next          = bus_data;
          end
        end
        POS_HL_R: begin
          regs_next[RI_HL] = bus_addr;
          regs_next[RI_R]  = {8'h00, r_val};
          patch_r_next     = r_val - 8'd2;
        end
        POS_I:   regs_next[RI_I]   = {8'h00, bus_data};
        POS_DE:  regs_next[RI_DE]  = bus_addr;
        POS_BC:  regs_next[RI_BC]  = bus_addr;
        POS_HL2: regs_next[RI_HL2] = bus_addr;
        POS_DE2: regs_next[RI_DE2] = bus_addr;
        POS_BC2: regs_next[RI_BC2] = bus_addr;
        default: ;
      endcase
      if (position == POS_GRAB) status.progress = PROG_GRAB;
    end else begin
      if (position == POS_FIRST) regs_next[RI_PC] = bus_addr;
      status.drive_byte = prog_byte;
      pending_next      = 1'b0;
      if (position == POS_END) begin
        position_next   = POS_FIRST;
        status.done     = 1'b1;
        status.progress = PROG_DONE;
      end else begin
        position_next = position + 6'd1;
        if (position_next == POS_GRAB) status.progress = PROG_GRAB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= POS_FIRST;
      pending  <= 1'b0;
      patch_r  <= 8'h00;
      patch_a  <= 8'h00;
      patch_f  <= 8'h00;
      for (int i = 0; i < NumRegs; i++) regs[i] <= 16'h0000;
    end else if (accept) begin
      position <= position_next;
      pending  <= pending_next;
      patch_r  <= patch_r_next;
      patch_a  <= patch_a_next;
      patch_f  <= patch_f_next;
      regs     <= regs_next;
    end
  end

  assign rd_value = regs[rd_idx];

endmodule

`default_nettype wire

// ===== src/z80_register_capture_injector.sv =====
// z80_register_capture_injector: top level, result register and register run
// sequencer around zrci_core. Uses zrci_pkg, zrci_in_if, zrci_out_if.
//
//   channel | dir | word
//   item    | in  | bus_addr, bus_data, is_write
//   result  | out | drive_byte, inject_flag, progress, reg_valid, reg_index,
//           |     | reg_value, last
//
// one bus cycle word per clock while item is ready; its result is registered and
// shows the next cycle; a program-ending word gives a run of 14 result words, one
// a cycle unless stalled, and item is held off until the last of them is loaded
// item.ready follows the result register: a new word enters as the held one leaves
// synchronous reset clears position, patch bytes and captured registers
`default_nettype none

module z80_register_capture_injector (
  input wire logic  clk,
  input wire logic  rst,
  zrci_in_if.sink   item,
  zrci_out_if.source result
);
  import zrci_pkg::*;

  zrci_status_t status;
  reg_idx_t     rd_idx;
  logic [15:0]  rd_value;
  logic         item_acc;
  logic         out_free;
  logic         out_valid;
  logic         run_active;
  reg_idx_t     run_cnt;
  logic         run_step;

  logic [7:0]  drive_byte;
  progress_t   progress;
  logic        reg_valid;
  reg_idx_t    reg_index;
  logic [15:0] reg_value;
  logic        last;

  assign out_free = !out_valid || result.ready;
  assign item.ready = !run_active && out_free;
  assign item_acc = item.valid && item.ready;
  assign run_step = run_active && out_free;
  assign rd_idx = run_active ? run_cnt : RI_PC;

  zrci_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (item_acc),
    .bus_addr (item.bus_addr),
    .bus_data (item.bus_data),
    .is_write (item.is_write),
    .rd_idx   (rd_idx),
    .status   (status),
    .rd_value (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      run_active <= 1'b0;
      run_cnt    <= RI_PC;
    end else if (item_acc) begin
      out_valid  <= 1'b1;
      run_active <= status.done;
      run_cnt    <= RI_SP;
    end else if (run_step) begin
      out_valid  <= 1'b1;
      run_active <= (run_cnt != RI_LAST);
      run_cnt    <= run_cnt + 4'd1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      drive_byte <= status.drive_byte;
      progress   <= status.progress;
      reg_valid  <= status.done;
      reg_index  <= RI_PC;
      reg_value  <= status.done ? rd_value : 16'h0000;
      last       <= !status.done;
    end else if (run_step) begin
      reg_index <= run_cnt;
      reg_value <= rd_value;
      last      <= (run_cnt == RI_LAST);
    end
  end

  assign result.valid       = out_valid;
  assign result.drive_byte  = drive_byte;
  assign result.inject_flag = 1'b1;
  assign result.progress    = progress;
  assign result.reg_valid   = reg_valid;
  assign result.reg_index   = reg_index;
  assign result.reg_value   = reg_value;
  assign result.last        = last;

endmodule

`default_nettype wire

// ===== src/zrci_checker.sv =====
// zrci_checker: port-level assertions for the register capture injector,
// bound to the top level. Uses zrci_pkg.
`default_nettype none

module zrci_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       res_inject,
  input wire logic [1:0] res_progress,
  input wire logic       res_reg_valid,
  input wire logic [3:0] res_reg_index,
  input wire logic       res_last
);
  import zrci_pkg::*;

  // register words only come with a done progress
  a_reg_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_reg_valid |-> res_progress == PROG_DONE)
    else $error("register word without done progress");

  // a plain word is always the last of its bus cycle
  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_reg_valid |-> res_last && res_inject)
    else $error("plain word not marked last");

  // a run advances by one register each taken word
  a_run_step: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res_reg_valid && !res_last |=>
      res_valid && res_reg_valid && res_reg_index == $past(res_reg_index) + 4'd1)
    else $error("register run broken");

  // no bus word taken mid run
  a_run_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_reg_valid && !res_last |-> !(item_valid && item_ready))
    else $error("item taken during register run");

  // the run ends on the last register
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_reg_valid && res_last |-> res_reg_index == RI_LAST)
    else $error("run ended on wrong register");

endmodule

bind z80_register_capture_injector zrci_checker u_zrci_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_inject    (result.inject_flag),
  .res_progress  (result.progress),
  .res_reg_valid (result.reg_valid),
  .res_reg_index (result.reg_index),
  .res_last      (result.last)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: drives bus cycles into z80_register_capture_injector and checks every
// result word against an in-bench model of the query program and register capture.
// Uses zrci_pkg, zrci_in_if and zrci_out_if from src.
`default_nettype none

module testbench;
  import zrci_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int MaxPrinted = 40;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        wr;
  } bus_cycle_t;

  typedef struct packed {
    logic [7:0]  drive_byte;
    progress_t   progress;
    logic        reg_valid;
    reg_idx_t    reg_index;
    logic [15:0] reg_value;
    logic        last;
  } result_word_t;

  localparam logic [7:0] QueryRom [ProgLen] = '{
    8'hF5, 8'hED, 8'h5F, 8'h77, 8'hED, 8'h57, 8'h77, 8'h33, 8'h33, 8'h12,
    8'h02, 8'hD9, 8'h77, 8'h12, 8'h02, 8'hD9, 8'h08, 8'hF5, 8'h33, 8'h33,
    8'h08, 8'hDD, 8'hE5, 8'h33, 8'h33, 8'hFD, 8'hE5, 8'h3E, 8'h00, 8'hED,
    8'h4F, 8'hF1, 8'h00, 8'h00, 8'h18, 8'hDE
  };

  logic clk;
  logic rst;

  zrci_in_if  item_ch ();
  zrci_out_if result_ch ();

  z80_register_capture_injector u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // model state
  pos_t        prog_pos;
  logic        low_half_next;
  logic [7:0]  r_patch;
  logic [7:0]  a_patch;
  logic [7:0]  f_patch;
  logic [15:0] cap_regs [NumRegs];

  bus_cycle_t   bus_cycles [$];
  result_word_t predicted_words [$];
  pos_t         gen_pos;

  int send_idle_pct;
  int stall_pct;
  int cycle_count;
  int cycles_queued;
  int cycles_accepted;
  int words_checked;
  int runs_done;
  int mismatches;
  logic item_taken;
  bus_cycle_t next_cycle;
  result_word_t want;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] program_byte(input pos_t p);
    logic [7:0] b;
    if (p == POS_R_PATCH) b = r_patch;
    else if (p == POS_F_PATCH) b = f_patch;
    else if (p == POS_A_PATCH) b = a_patch;
    else if (p < ProgLen) b = QueryRom[p];
    else b = 8'h00;
    return b;
  endfunction

  task automatic take_push_byte(input reg_idx_t idx, input logic [7:0] d);
    if (!low_half_next) begin
      cap_regs[idx][15:8] = d;
      low_half_next = 1'b1;
    end else begin
      cap_regs[idx][7:0] = d;
    end
  endtask

  task automatic predict_bus_cycle(input bus_cycle_t c);
    logic [7:0] drive;
    logic [7:0] r;
    progress_t prog;
    result_word_t w;
    drive = 8'h00;
    prog = PROG_GENERAL;
    if (c.wr) begin
      case (prog_pos)
        POS_AF_PUSH: begin
          if (!low_half_next) begin
            cap_regs[RI_SP] = c.addr + 16'd1;
            cap_regs[RI_AF] = {c.data, 8'h00};
            a_patch = c.data;
            low_half_next = 1'b1;
          end else begin
            cap_regs[RI_AF][7:0] = c.data;
            f_patch = c.data;
          end
        end
        POS_HL_R: begin
          r = c.data - 8'd3;
          cap_regs[RI_HL] = c.addr;
          cap_regs[RI_R] = {8'h00, r};
          r_patch = r - 8'd2;
        end
        POS_I:        cap_regs[RI_I] = {8'h00, c.data};
        POS_DE:       cap_regs[RI_DE] = c.addr;
        POS_BC:       cap_regs[RI_BC] = c.addr;
        POS_HL2:      cap_regs[RI_HL2] = c.addr;
        POS_DE2:      cap_regs[RI_DE2] = c.addr;
        POS_BC2:      cap_regs[RI_BC2] = c.addr;
        POS_AF2_PUSH: take_push_byte(RI_AF2, c.data);
        POS_IX_PUSH:  take_push_byte(RI_IX, c.data);
        POS_IY_PUSH:  take_push_byte(RI_IY, c.data);
        default: ;
      endcase
    end else begin
      if (prog_pos == POS_FIRST) cap_regs[RI_PC] = c.addr;
      drive = program_byte(prog_pos);
      prog_pos = prog_pos + 1'b1;
      low_half_next = 1'b0;
    end
    if (prog_pos >= ProgLen) begin
      prog_pos = POS_FIRST;
      prog = PROG_DONE;
    end else if (prog_pos == POS_GRAB) begin
      prog = PROG_GRAB;
    end
    w.drive_byte = drive;
    w.progress = prog;
    if (prog != PROG_DONE) begin
      w.reg_valid = 1'b0;
      w.reg_index = RI_PC;
      w.reg_value = 16'h0000;
      w.last = 1'b1;
      predicted_words.push_back(w);
    end else begin
      for (int k = 0; k < NumRegs; k++) begin
        w.reg_valid = 1'b1;
        w.reg_index = reg_idx_t'(k);
        w.reg_value = cap_regs[k];
        w.last = (reg_idx_t'(k) == RI_LAST);
        predicted_words.push_back(w);
      end
    end
  endtask

  function automatic int writes_at(input pos_t p);
    int n;
    case (p)
      POS_AF_PUSH, POS_AF2_PUSH, POS_IX_PUSH, POS_IY_PUSH: n = 2;
      POS_HL_R, POS_I, POS_DE, POS_BC, POS_HL2, POS_DE2, POS_BC2: n = 1;
      POS_GRAB: n = $urandom_range(1);
      default: n = 0;
    endcase
    return n;
  endfunction

  task automatic add_cycle(input logic [15:0] addr, input logic [7:0] data, input logic wr);
    bus_cycle_t c;
    c.addr = addr;
    c.data = data;
    c.wr = wr;
    bus_cycles.push_back(c);
    cycles_queued++;
    if (!wr) gen_pos = (gen_pos == POS_END) ? POS_FIRST : gen_pos + 1'b1;
  endtask

  // one pass of the query program with random content, a little noise, then loose cycles
  task automatic queue_query_run();
    int nwr;
    for (int p = 0; p < ProgLen; p++) begin
      add_cycle(16'($urandom), 8'($urandom), 1'b0);
      nwr = writes_at(gen_pos);
      if ($urandom_range(99) < 8) nwr = $urandom_range(3);
      for (int k = 0; k < nwr; k++)
        add_cycle(16'($urandom), 8'($urandom), 1'b1);
    end
    for (int k = 0; k < 3; k++)
      add_cycle(16'($urandom), 8'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    while (cycles_accepted != cycles_queued || predicted_words.size() != 0)
      @(posedge clk);
  endtask

  // acceptance, prediction and cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("run stopped at cycle limit with %0d words still due", predicted_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    item_taken <= !rst && item_ch.valid && item_ch.ready;
    if (!rst && item_ch.valid && item_ch.ready) begin
      predict_bus_cycle('{item_ch.bus_addr, item_ch.bus_data, item_ch.is_write});
      cycles_accepted <= cycles_accepted + 1;
    end
  end

  // driver and receiver, both at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_taken) begin
      if (bus_cycles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cycle = bus_cycles.pop_front();
        item_ch.valid <= 1'b1;
        item_ch.bus_addr <= next_cycle.addr;
        item_ch.bus_data <= next_cycle.data;
        item_ch.is_write <= next_cycle.wr;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (predicted_words.size() == 0) begin
        report_mismatch("result word with nothing predicted");
      end else begin
        want = predicted_words.pop_front();
        words_checked++;
        if (want.last && want.progress == PROG_DONE) runs_done++;
        if (result_ch.drive_byte !== want.drive_byte)
          report_mismatch($sformatf("drive_byte %h, want %h", result_ch.drive_byte,
                                    want.drive_byte));
        if (result_ch.inject_flag !== 1'b1)
          report_mismatch($sformatf("inject_flag %b, want 1", result_ch.inject_flag));
        if (result_ch.progress !== want.progress)
          report_mismatch($sformatf("progress %0d, want %0d", result_ch.progress,
                                    want.progress));
        if (result_ch.reg_valid !== want.reg_valid)
          report_mismatch($sformatf("reg_valid %b, want %b", result_ch.reg_valid,
                                    want.reg_valid));
        if (result_ch.reg_index !== want.reg_index)
          report_mismatch($sformatf("reg_index %0d, want %0d", result_ch.reg_index,
                                    want.reg_index));
        if (result_ch.reg_value !== want.reg_value)
          report_mismatch($sformatf("reg_value %h, want %h (reg %0d)", result_ch.reg_value,
                                    want.reg_value, want.reg_index));
        if (result_ch.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", result_ch.last, want.last));
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.bus_addr = 16'h0000;
    item_ch.bus_data = 8'h00;
    item_ch.is_write = 1'b0;
    result_ch.ready = 1'b0;
    item_taken = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    cycle_count = 0;
    cycles_queued = 0;
    cycles_accepted = 0;
    words_checked = 0;
    runs_done = 0;
    mismatches = 0;
    gen_pos = POS_FIRST;
    prog_pos = POS_FIRST;
    low_half_next = 1'b0;
    r_patch = 8'h00;
    a_patch = 8'h00;
    f_patch = 8'h00;
    for (int k = 0; k < NumRegs; k++) cap_regs[k] = 16'h0000;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // write before any read decodes nothing
    add_cycle(16'hFFFF, 8'hFF, 1'b1);
    add_cycle(16'hFFFF, 8'h00, 1'b0);
    // af push: sp wraps, then low byte taken by every later write
    add_cycle(16'hFFFF, 8'hFF, 1'b1);
    add_cycle(16'h0000, 8'h00, 1'b1);
    add_cycle(16'h1234, 8'hA5, 1'b1);
    add_cycle(16'h0000, 8'hFF, 1'b0);
    add_cycle(16'h8000, 8'h00, 1'b0);
    add_cycle(16'h7FFF, 8'h55, 1'b0);
    // r capture wraps below zero
    add_cycle(16'h0000, 8'h00, 1'b1);
    add_cycle(16'hFFFF, 8'h02, 1'b1);
    add_cycle(16'hFFFF, 8'hFF, 1'b1);
    add_cycle(16'h0001, 8'h01, 1'b0);
    wait_drained();

    send_idle_pct = 0;   stall_pct = 0;
    queue_query_run();
    wait_drained();
    send_idle_pct = 71;  stall_pct = 0;
    queue_query_run();
    wait_drained();
    send_idle_pct = 0;   stall_pct = 71;
    queue_query_run();
    wait_drained();
    send_idle_pct = 12;  stall_pct = 12;
    queue_query_run();
    wait_drained();

    repeat (20) @(posedge clk);
    $display("%0d bus cycles sent, %0d result words checked, %0d full register runs seen",
             cycles_accepted, words_checked, runs_done);
    $display("%0d mismatches over four pacing phases after the directed cycles", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
